### hw/rtl/etfi_pkg.sv
// ----------------------------------------------------------------------------
// etfi_pkg: shared definitions for the escape-time fractal iteration unit
// Field widths of the fixed ports, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package etfi_pkg;

    // Fixed widths of the ports
    localparam int MAX_ITER_W = 16;
    localparam int COORD_IN_W = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Iteration cutoff after reset
    localparam logic [MAX_ITER_W-1:0] MAX_ITER_RESET = 16'd1024;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ITER   = 2'd0,
        CFG_JULIA_MODE = 2'd1,
        CFG_JULIA_RE   = 2'd2,
        CFG_JULIA_IM   = 2'd3
    } t_cfg_idx;

    // Sequencer states: one iteration is SQ_RE, SQ_IM, CROSS, UPDATE
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_SQ_RE  = 3'd1,
        ST_SQ_IM  = 3'd2,
        ST_CROSS  = 3'd3,
        ST_UPDATE = 3'd4
    } t_state;

endpackage

### hw/rtl/escape_time_fractal_iteration_unit.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_iteration_unit: Mandelbrot / Julia escape-time counter
// Iterates z <- z*z + c on one fixed-point point and reports the escape count.
// ----------------------------------------------------------------------------
// Usage:
//   Configure max_iter, julia_mode, julia_re and julia_im through the write
//   port (i_cfg_we, i_cfg_idx, i_cfg_wdata) while the unit is idle.
//   A point is taken at a clock edge with start high and busy low. busy then
//   stays high until the result beat: o_valid is high for exactly one cycle
//   with o_escape_count, and busy drops in that same cycle, so the next point
//   may be started right away. The receiver cannot stall the result.
// Iteration:
//   Each iteration steps through SQ_RE, SQ_IM, CROSS and UPDATE: the one
//   shared multiplier forms zr*zr, zi*zi and zr*zi in turn, then the update
//   adds c and checks the range.
// Reset:
//   Synchronous, active low. Registers return to max_iter 1024, Mandelbrot
//   mode, Julia constant 0; any point in flight is dropped.
// ----------------------------------------------------------------------------
module escape_time_fractal_iteration_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 28
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port
    input  logic                                  i_cfg_we,
    input  logic [etfi_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [etfi_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    // Command
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [etfi_pkg::COORD_IN_W-1:0] i_point_re,
    input  logic signed [etfi_pkg::COORD_IN_W-1:0] i_point_im,
    // Result
    output logic                                  o_valid,
    output logic [etfi_pkg::MAX_ITER_W-1:0]       o_escape_count
);

    // z holds values up to magnitude 2, or a full starting coordinate
    localparam int ZW = (COORD_WIDTH > FRAC_BITS + 3) ? COORD_WIDTH : FRAC_BITS + 3;
    localparam int PW = 2 * ZW;
    localparam int SW = PW + 1;
    localparam int XW = (COORD_WIDTH > etfi_pkg::COORD_IN_W) ?
                        COORD_WIDTH : etfi_pkg::COORD_IN_W;
    localparam int MW = etfi_pkg::MAX_ITER_W;

    localparam logic signed [SW-1:0] FOUR = SW'(1) << (2 * FRAC_BITS + 2);
    localparam logic signed [SW-1:0] TWO  = SW'(2) << FRAC_BITS;

    // Low COORD_WIDTH bits of a field, sign extended
    function automatic logic signed [ZW-1:0] f_coord(
        input logic [etfi_pkg::COORD_IN_W-1:0] v
    );
        logic [XW-1:0] x;
        x = XW'(v);
        return ZW'($signed(x[COORD_WIDTH-1:0]));
    endfunction

    // Configuration registers
    logic [MW-1:0]                      r_max_iter;
    logic                               r_julia_mode;
    logic [etfi_pkg::COORD_IN_W-1:0]    r_julia_re;
    logic [etfi_pkg::COORD_IN_W-1:0]    r_julia_im;

    // Sequencer and datapath registers
    etfi_pkg::t_state      r_state, n_state;
    logic                  r_valid, n_valid;
    logic [MW-1:0]         r_count, n_count;
    logic [MW-1:0]         r_cnt, n_cnt;
    logic signed [ZW-1:0]  r_zr, n_zr;
    logic signed [ZW-1:0]  r_zi, n_zi;
    logic signed [ZW-1:0]  r_cr, n_cr;
    logic signed [ZW-1:0]  r_ci, n_ci;
    logic signed [PW-1:0]  r_srr, n_srr;
    logic signed [SW-1:0]  r_diff, n_diff;

    // Multiplier hookup
    logic                  w_mul_en;
    logic signed [ZW-1:0]  w_mul_a;
    logic signed [ZW-1:0]  w_mul_b;
    logic signed [PW-1:0]  w_p;

    // Escape tests and next z
    logic                  w_accept;
    logic signed [SW-1:0]  w_mag;
    logic                  w_mag_esc;
    logic                  w_at_limit;
    logic signed [SW-1:0]  w_re;
    logic signed [SW-1:0]  w_im;
    logic                  w_range_esc;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter   <= etfi_pkg::MAX_ITER_RESET;
            r_julia_mode <= 1'b0;
            r_julia_re   <= '0;
            r_julia_im   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                etfi_pkg::CFG_MAX_ITER:   r_max_iter   <= i_cfg_wdata[MW-1:0];
                etfi_pkg::CFG_JULIA_MODE: r_julia_mode <= i_cfg_wdata[0];
                etfi_pkg::CFG_JULIA_RE:   r_julia_re   <= i_cfg_wdata;
                etfi_pkg::CFG_JULIA_IM:   r_julia_im   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Shared multiplier: zr*zr, then zi*zi, then zr*zi
    assign w_mul_en = (r_state == etfi_pkg::ST_SQ_RE) || (r_state == etfi_pkg::ST_SQ_IM) ||
                      (r_state == etfi_pkg::ST_CROSS);
    assign w_mul_a  = (r_state == etfi_pkg::ST_SQ_IM) ? r_zi : r_zr;
    assign w_mul_b  = (r_state == etfi_pkg::ST_SQ_RE) ? r_zr : r_zi;

    etfi_mul #(
        .WIDTH (ZW)
    ) u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_p)
    );

    assign w_accept = start && (r_state == etfi_pkg::ST_IDLE);

    // Magnitude of current z (product holds zi*zi in CROSS)
    assign w_mag      = SW'(r_srr) + SW'(w_p);
    assign w_mag_esc  = (r_cnt != '0) && (w_mag > FOUR);
    assign w_at_limit = (r_cnt == r_max_iter);

    // New z (product holds zr*zi in UPDATE); 2*x >>> F equals x >>> (F-1)
    assign w_re = (r_diff >>> FRAC_BITS) + SW'(r_cr);
    assign w_im = SW'(w_p >>> (FRAC_BITS - 1)) + SW'(r_ci);
    assign w_range_esc = (w_re > TWO) || (w_re < -TWO) || (w_im > TWO) || (w_im < -TWO);

    // Hold the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= etfi_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Advance datapath registers
    always_ff @(posedge i_clk) begin
        r_count <= n_count;
        r_cnt   <= n_cnt;
        r_zr    <= n_zr;
        r_zi    <= n_zi;
        r_cr    <= n_cr;
        r_ci    <= n_ci;
        r_srr   <= n_srr;
        r_diff  <= n_diff;
    end

    // Next state and datapath
    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        n_count = r_count;
        n_cnt   = r_cnt;
        n_zr    = r_zr;
        n_zi    = r_zi;
        n_cr    = r_cr;
        n_ci    = r_ci;
        n_srr   = r_srr;
        n_diff  = r_diff;
        case (r_state)
            etfi_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_cnt   = '0;
                    n_state = etfi_pkg::ST_SQ_RE;
                    if (r_julia_mode) begin
                        n_zr = f_coord(i_point_re);
                        n_zi = f_coord(i_point_im);
                        n_cr = f_coord(r_julia_re);
                        n_ci = f_coord(r_julia_im);
                    end else begin
                        n_zr = '0;
                        n_zi = '0;
                        n_cr = f_coord(i_point_re);
                        n_ci = f_coord(i_point_im);
                    end
                end
            end
            etfi_pkg::ST_SQ_RE: begin
                n_state = etfi_pkg::ST_SQ_IM;
            end
            etfi_pkg::ST_SQ_IM: begin
                n_srr   = w_p;
                n_state = etfi_pkg::ST_CROSS;
            end
            etfi_pkg::ST_CROSS: begin
                n_diff = SW'(r_srr) - SW'(w_p);
                if (w_mag_esc) begin
                    n_valid = 1'b1;
                    n_count = r_cnt;
                    n_state = etfi_pkg::ST_IDLE;
                end else if (w_at_limit) begin
                    n_valid = 1'b1;
                    n_count = '0;
                    n_state = etfi_pkg::ST_IDLE;
                end else begin
                    n_state = etfi_pkg::ST_UPDATE;
                end
            end
            etfi_pkg::ST_UPDATE: begin
                n_cnt = MW'(r_cnt + 1'b1);
                if (w_range_esc) begin
                    n_valid = 1'b1;
                    n_count = MW'(r_cnt + 1'b1);
                    n_state = etfi_pkg::ST_IDLE;
                end else begin
                    n_zr    = w_re[ZW-1:0];
                    n_zi    = w_im[ZW-1:0];
                    n_state = etfi_pkg::ST_SQ_RE;
                end
            end
            default: begin
                n_state = etfi_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != etfi_pkg::ST_IDLE);
    assign o_valid        = r_valid;
    assign o_escape_count = r_count;

    // A result beat only follows the end of an iteration step
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($past(r_state) == etfi_pkg::ST_CROSS) ||
                    ($past(r_state) == etfi_pkg::ST_UPDATE))
        else $error("result beat without a finishing step");

    // The unit is idle while a result beat is shown
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == etfi_pkg::ST_IDLE))
        else $error("result beat while busy");

    // One point gives one beat
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("repeated result beat");

    // An accepted point starts an iteration
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == etfi_pkg::ST_SQ_RE))
        else $error("accepted point did not start");

    // The update step is entered only from the cross product step
    a_update_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == etfi_pkg::ST_UPDATE) |-> ($past(r_state) == etfi_pkg::ST_CROSS))
        else $error("update step out of order");

endmodule

### hw/rtl/etfi_mul.sv
// ----------------------------------------------------------------------------
// etfi_mul: shared signed multiplier
// Full-width signed product with a registered output; holds when disabled.
// ----------------------------------------------------------------------------
module etfi_mul #(
    parameter int WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [WIDTH-1:0]    i_a,
    input  logic signed [WIDTH-1:0]    i_b,
    output logic signed [2*WIDTH-1:0]  o_p
);

    logic signed [2*WIDTH-1:0] r_p;

    // Register the product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule
